// File: rtl/core/zvp_pkg.sv
// ============================================================================
// zvp_pkg
// Shared widths, codes and controller/datapath interface types for the
// edge-push pan viewport core.
// ============================================================================
package zvp_pkg;

    // Field widths.
    localparam int OPW   = 2;    // operation code
    localparam int MONW  = 4;    // monitor field
    localparam int PW    = 24;   // pointer, signed Q16.8
    localparam int CW    = 16;   // rectangle origin, whole pixels
    localparam int SZW   = 15;   // rectangle size, whole pixels
    localparam int ZW    = 16;   // zoom, Q8.8
    localparam int EW    = 2;    // entry edge code
    localparam int VW    = 23;   // view origin, Q15.8
    localparam int FRW   = 16;   // band fraction, Q0.16
    localparam int BW    = 23;   // band width, Q15.8

    // Internal arithmetic widths.
    localparam int DFW   = 26;           // pointer minus origin minus source
    localparam int PRW   = DFW + ZW + 1; // that difference times zoom
    localparam int SCW   = 34;           // screen position
    localparam int TW    = 36;           // signed working width

    // Iterative divider.
    localparam int DNW      = 44;            // dividend and quotient width
    localparam int DIV_BPC  = 4;             // quotient bits per cycle
    localparam int DIV_ITER = DNW / DIV_BPC;
    localparam int DIV_CW   = $clog2(DIV_ITER);

    // Configuration port.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 23;

    localparam logic [CFG_IW-1:0] CFG_PUSH_ENABLE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BAND_FRACTION = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BAND_MIN     = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_BAND_MAX     = 2'd3;

    localparam logic [FRW-1:0] RST_BAND_FRACTION = 16'd7864;
    localparam logic [BW-1:0]  RST_BAND_MIN      = 23'd20480;
    localparam logic [BW-1:0]  RST_BAND_MAX      = 23'd76800;

    // Operations.
    localparam logic [OPW-1:0] OP_SET_RECT  = 2'd0;
    localparam logic [OPW-1:0] OP_SET_ZOOM  = 2'd1;
    localparam logic [OPW-1:0] OP_PUSH      = 2'd2;
    localparam logic [OPW-1:0] OP_PLACE     = 2'd3;

    localparam logic [ZW-1:0] ZOOM_ONE = 16'd256;

    // Datapath commands, one per cycle.
    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_RECT, C_MUL, C_SCREEN, C_ZDIV, C_ZSRC, C_MDIV,
        C_MAXO, C_PDIV, C_PSRC, C_FIN, C_ZOOM, C_LDIV, C_PLACE, C_OUT
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
        logic      axis;    // 0 works on x, 1 on y
    } t_cmd;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           push_go;    // panning enabled and view magnified
        logic           push_need;  // pointer sits inside an edge band
        logic           edge_far;   // right or bottom entry edge
        logic           div_done;
    } t_stat;

endpackage

// File: rtl/core/zvp_div.sv
// ============================================================================
// zvp_div
// Unsigned restoring divider, four quotient bits per cycle.
// ============================================================================
module zvp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [zvp_pkg::DNW-1:0]  i_num,
    input  logic [zvp_pkg::ZW-1:0]   i_den,
    output logic                     o_done,
    output logic [zvp_pkg::DNW-1:0]  o_quo
);
    import zvp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [ZW:0]       r_rem;
    logic [ZW-1:0]     r_den;
    logic [DNW-1:0]    r_quo;
    logic [ZW:0]       n_rem;
    logic [DNW-1:0]    n_quo;

    // The quotient register shifts the dividend out at the top while the
    // quotient bits come in at the bottom.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BPC; k++) begin
            n_rem = {n_rem[ZW-1:0], n_quo[DNW-1]};
            n_quo = {n_quo[DNW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= DIV_CW'(DIV_ITER - 1);
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/core/zvp_ctrl.sv
// ============================================================================
// zvp_ctrl
// Sequencer: walks each operation through the datapath one axis at a time
// and owns both handshakes.
// ============================================================================
module zvp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output zvp_pkg::t_cmd  o_cmd,
    input  zvp_pkg::t_stat i_stat
);
    import zvp_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DISP   = 20'h00002,
        S_RECT   = 20'h00004,
        S_MUL    = 20'h00008,
        S_SCREEN = 20'h00010,
        S_ZDIV   = 20'h00020,
        S_ZWAIT  = 20'h00040,
        S_ZSRC   = 20'h00080,
        S_MDIV   = 20'h00100,
        S_MWAIT  = 20'h00200,
        S_MAXO   = 20'h00400,
        S_PDIV   = 20'h00800,
        S_PWAIT  = 20'h01000,
        S_PSRC   = 20'h02000,
        S_FIN    = 20'h04000,
        S_ZOOM   = 20'h08000,
        S_LDIV   = 20'h10000,
        S_LWAIT  = 20'h20000,
        S_PLACE  = 20'h40000,
        S_OUT    = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        o_cmd.code  = C_NONE;
        o_cmd.axis  = r_axis;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.code = C_LOAD;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_axis = 1'b0;
                unique case (i_stat.op)
                    OP_SET_RECT: n_state = S_RECT;
                    OP_SET_ZOOM: n_state = S_MUL;
                    OP_PUSH:     n_state = i_stat.push_go ? S_MDIV : S_OUT;
                    OP_PLACE:    n_state = S_LDIV;
                endcase
            end
            S_RECT: begin
                o_cmd.code = C_RECT;
                n_state    = S_MDIV;
            end
            S_MUL: begin
                o_cmd.code = C_MUL;
                n_state    = S_SCREEN;
            end
            S_SCREEN: begin
                o_cmd.code = C_SCREEN;
                n_state    = (i_stat.op == OP_SET_ZOOM) ? S_ZDIV : S_PDIV;
            end
            S_ZDIV: begin
                o_cmd.code = C_ZDIV;
                n_state    = S_ZWAIT;
            end
            S_ZWAIT: begin
                if (i_stat.div_done) n_state = S_ZSRC;
            end
            S_ZSRC: begin
                o_cmd.code = C_ZSRC;
                n_state    = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.code = C_MDIV;
                n_state    = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.div_done) n_state = S_MAXO;
            end
            S_MAXO: begin
                o_cmd.code = C_MAXO;
                n_state    = (i_stat.op == OP_PUSH) ? S_MUL : S_FIN;
            end
            S_PDIV: begin
                o_cmd.code = C_PDIV;
                n_state    = i_stat.push_need ? S_PWAIT : S_FIN;
            end
            S_PWAIT: begin
                if (i_stat.div_done) n_state = S_PSRC;
            end
            S_PSRC: begin
                o_cmd.code = C_PSRC;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.code = C_FIN;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = (i_stat.op == OP_SET_ZOOM) ? S_MUL : S_MDIV;
                end else begin
                    n_state = (i_stat.op == OP_SET_ZOOM) ? S_ZOOM : S_OUT;
                end
            end
            S_ZOOM: begin
                o_cmd.code = C_ZOOM;
                n_state    = S_OUT;
            end
            S_LDIV: begin
                o_cmd.code = C_LDIV;
                n_state    = i_stat.edge_far ? S_LWAIT : S_PLACE;
            end
            S_LWAIT: begin
                if (i_stat.div_done) n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.code = C_PLACE;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.code  = C_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/zvp_dpath.sv
// ============================================================================
// zvp_dpath
// Viewport table, configuration registers and the arithmetic for one axis,
// with the shared divider.
// ============================================================================
module zvp_dpath #(
    parameter int MAX_MONITORS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  zvp_pkg::t_cmd                      i_cmd,
    output zvp_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [zvp_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [zvp_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic [zvp_pkg::OPW-1:0]            i_operation,
    input  logic [zvp_pkg::MONW-1:0]           i_monitor,
    input  logic signed [zvp_pkg::PW-1:0]      i_pointer_x,
    input  logic signed [zvp_pkg::PW-1:0]      i_pointer_y,
    input  logic signed [zvp_pkg::CW-1:0]      i_rect_left,
    input  logic signed [zvp_pkg::CW-1:0]      i_rect_top,
    input  logic [zvp_pkg::SZW-1:0]            i_rect_width,
    input  logic [zvp_pkg::SZW-1:0]            i_rect_height,
    input  logic [zvp_pkg::ZW-1:0]             i_zoom_request,
    input  logic [zvp_pkg::EW-1:0]             i_entry_edge,
    output logic [zvp_pkg::VW-1:0]             o_view_x,
    output logic [zvp_pkg::VW-1:0]             o_view_y,
    output logic signed [zvp_pkg::PW-1:0]      o_placed_x,
    output logic signed [zvp_pkg::PW-1:0]      o_placed_y
);
    import zvp_pkg::*;

    localparam int MW = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;

    // Configuration.
    logic           r_pe;
    logic [FRW-1:0] r_frac;
    logic [BW-1:0]  r_bmin;
    logic [BW-1:0]  r_bmax;

    // Viewport table.
    logic signed [CW-1:0] r_left [MAX_MONITORS];
    logic signed [CW-1:0] r_top  [MAX_MONITORS];
    logic [SZW-1:0]       r_wid  [MAX_MONITORS];
    logic [SZW-1:0]       r_hgt  [MAX_MONITORS];
    logic [ZW-1:0]        r_zoom [MAX_MONITORS];
    logic [VW-1:0]        r_srcx [MAX_MONITORS];
    logic [VW-1:0]        r_srcy [MAX_MONITORS];

    // Current item.
    logic [OPW-1:0]       r_op;
    logic [MW-1:0]        r_m;
    logic signed [PW-1:0] r_px, r_py;
    logic signed [CW-1:0] r_rl, r_rt;
    logic [SZW-1:0]       r_rw, r_rh;
    logic [ZW-1:0]        r_zreq;
    logic [EW-1:0]        r_edge;
    logic signed [PW-1:0] r_plx, r_ply;

    // Work registers.
    logic signed [PRW-1:0] r_prod;
    logic [SZW+FRW-1:0]    r_bprod;
    logic signed [SCW-1:0] r_scr;
    logic [BW-1:0]         r_band;
    logic                  r_neg;
    logic                  r_lo;
    logic signed [TW-1:0]  r_tmp;
    logic [VW-1:0]         r_maxo;

    // Result registers.
    logic [VW-1:0]        r_vx, r_vy;
    logic signed [PW-1:0] r_ox, r_oy;

    // Divider hookup.
    logic           w_start;
    logic [DNW-1:0] w_num;
    logic [ZW-1:0]  w_den;
    logic           w_done;
    logic [DNW-1:0] w_quo;

    // Per-axis operands and arithmetic.
    logic                  w_ax;
    logic [MW-1:0]         w_msat;
    logic signed [PW-1:0]  w_p;
    logic signed [CW-1:0]  w_o;
    logic [SZW-1:0]        w_sz;
    logic [VW-1:0]         w_src;
    logic [SZW-1:0]        w_new_w, w_new_h;
    logic [ZW-1:0]         w_zoom, w_zeff;
    logic signed [PW-1:0]  w_org;
    logic signed [TW-1:0]  w_org_t, w_p_t, w_src_t, w_maxo_t, w_band_t, w_scr_t;
    logic signed [TW-1:0]  w_q_t, w_qs, w_nx, w_len_t, w_lmb, w_pdiff, w_room;
    logic signed [TW-1:0]  w_push_t, w_cand, w_clamp, w_pl;
    logic signed [DFW-1:0] w_diff;
    logic signed [PRW-1:0] w_prod, w_adj, w_sh;
    logic [SZW+FRW-1:0]    w_bprod;
    logic [BW-1:0]         w_raw, w_band1, w_band;
    logic [SCW-1:0]        w_mag;
    logic                  w_lo, w_hi, w_need;
    logic [VW-1:0]         w_fin;
    logic signed [PW-1:0]  w_plsat;

    assign w_msat = ({1'b0, i_monitor} >= (MONW+1)'(MAX_MONITORS))
                    ? MW'(MAX_MONITORS - 1) : i_monitor[MW-1:0];

    always_comb begin
        // Placement works on the axis of the crossed edge.
        w_ax = (i_cmd.code == C_LDIV || i_cmd.code == C_PLACE) ? r_edge[1] : i_cmd.axis;
        w_p   = w_ax ? r_py : r_px;
        w_o   = w_ax ? r_top[r_m] : r_left[r_m];
        w_sz  = w_ax ? r_hgt[r_m] : r_wid[r_m];
        w_src = w_ax ? r_srcy[r_m] : r_srcx[r_m];
        w_zoom = r_zoom[r_m];
        w_zeff = (r_zreq < ZOOM_ONE) ? ZOOM_ONE : r_zreq;
        // Every divide of a zoom change uses the new zoom.
        w_den  = (r_op == OP_SET_ZOOM) ? w_zeff : w_zoom;
        w_new_w = (r_rw == '0) ? SZW'(1) : r_rw;
        w_new_h = (r_rh == '0) ? SZW'(1) : r_rh;

        w_org    = $signed({w_o, 8'h00});
        w_org_t  = $signed({{(TW-PW){w_org[PW-1]}}, w_org});
        w_p_t    = $signed({{(TW-PW){w_p[PW-1]}}, w_p});
        w_src_t  = $signed({{(TW-VW){1'b0}}, w_src});
        w_maxo_t = $signed({{(TW-VW){1'b0}}, r_maxo});

        w_diff  = DFW'(w_p_t - w_org_t - w_src_t);
        w_prod  = w_diff * $signed({1'b0, w_zoom});
        w_bprod = w_sz * r_frac;

        // Divide by 256 rounding toward zero.
        w_adj = r_prod + $signed({{(PRW-8){1'b0}}, {8{r_prod[PRW-1]}}});
        w_sh  = w_adj >>> 8;

        w_raw   = r_bprod[SZW+FRW-1:8];
        w_band1 = (w_raw < r_bmin) ? r_bmin : w_raw;
        w_band  = (w_band1 > r_bmax) ? r_bmax : w_band1;

        w_scr_t  = $signed({{(TW-SCW){r_scr[SCW-1]}}, r_scr});
        w_band_t = $signed({{(TW-BW){1'b0}}, r_band});
        w_mag    = r_scr[SCW-1] ? SCW'(-r_scr) : SCW'(r_scr);

        w_q_t = $signed({1'b0, w_quo[TW-2:0]});
        w_qs  = r_neg ? -w_q_t : w_q_t;
        w_nx  = w_p_t - w_org_t - w_qs;

        // Near edge first; only one side can pan per axis.
        w_len_t = $signed({{(TW-VW){1'b0}}, w_sz, 8'h00});
        w_lmb   = w_len_t - w_band_t;
        w_lo    = (w_scr_t < w_band_t);
        w_hi    = (w_scr_t > w_lmb);
        w_need  = (r_band != '0) && (w_lo || w_hi);
        w_pdiff = w_lo ? (w_band_t - w_scr_t) : (w_scr_t - w_lmb);
        w_room  = w_maxo_t - w_src_t;
        if (r_lo) begin
            w_push_t = w_src_t - ((w_q_t < w_src_t) ? w_q_t : w_src_t);
        end else begin
            w_push_t = w_src_t + ((w_q_t < w_room) ? w_q_t : w_room);
        end

        w_cand = (r_op == OP_SET_RECT) ? w_src_t : r_tmp;
        if (w_cand[TW-1]) begin
            w_clamp = '0;
        end else if (w_cand > w_maxo_t) begin
            w_clamp = w_maxo_t;
        end else begin
            w_clamp = w_cand;
        end
        w_fin = w_clamp[VW-1:0];

        w_pl = w_org_t + w_src_t
             + (r_edge[0] ? $signed({{(TW-VW){1'b0}}, w_quo[VW-1:0]}) : TW'(0));
        if (w_pl[TW-1:PW-1] == {(TW-PW+1){w_pl[TW-1]}}) begin
            w_plsat = w_pl[PW-1:0];
        end else begin
            w_plsat = w_pl[TW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end

        unique case (i_cmd.code)
            C_ZDIV:  w_num = {{(DNW-SCW-8){1'b0}}, w_mag, 8'h00};
            C_PDIV:  w_num = {{(DNW-SCW-8){1'b0}}, w_pdiff[SCW-1:0], 8'h00};
            default: w_num = {{(DNW-SZW-16){1'b0}}, w_sz, 16'h0000};
        endcase
        w_start = (i_cmd.code == C_ZDIV) || (i_cmd.code == C_MDIV)
               || (i_cmd.code == C_PDIV && w_need)
               || (i_cmd.code == C_LDIV && r_edge[0]);
    end

    zvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe   <= 1'b1;
            r_frac <= RST_BAND_FRACTION;
            r_bmin <= RST_BAND_MIN;
            r_bmax <= RST_BAND_MAX;
            for (int i = 0; i < MAX_MONITORS; i++) begin
                r_left[i] <= '0;
                r_top[i]  <= '0;
                r_wid[i]  <= SZW'(1);
                r_hgt[i]  <= SZW'(1);
                r_zoom[i] <= ZOOM_ONE;
                r_srcx[i] <= '0;
                r_srcy[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PUSH_ENABLE:   r_pe   <= i_cfg_data[0];
                    CFG_BAND_FRACTION: r_frac <= i_cfg_data[FRW-1:0];
                    CFG_BAND_MIN:      r_bmin <= i_cfg_data[BW-1:0];
                    CFG_BAND_MAX:      r_bmax <= i_cfg_data[BW-1:0];
                endcase
            end
            unique case (i_cmd.code)
                C_LOAD: begin
                    r_op   <= i_operation;
                    r_m    <= w_msat;
                    r_px   <= i_pointer_x;
                    r_py   <= i_pointer_y;
                    r_rl   <= i_rect_left;
                    r_rt   <= i_rect_top;
                    r_rw   <= i_rect_width;
                    r_rh   <= i_rect_height;
                    r_zreq <= i_zoom_request;
                    r_edge <= i_entry_edge;
                    r_plx  <= i_pointer_x;
                    r_ply  <= i_pointer_y;
                end
                C_RECT: begin
                    r_left[r_m] <= r_rl;
                    r_top[r_m]  <= r_rt;
                    r_wid[r_m]  <= w_new_w;
                    r_hgt[r_m]  <= w_new_h;
                end
                C_MUL: begin
                    r_prod  <= w_prod;
                    r_bprod <= w_bprod;
                end
                C_SCREEN: begin
                    r_scr  <= w_sh[SCW-1:0];
                    r_band <= w_band;
                end
                C_ZDIV:  r_neg  <= r_scr[SCW-1];
                C_ZSRC:  r_tmp  <= w_nx;
                C_MAXO:  r_maxo <= {w_sz, 8'h00} - w_quo[VW-1:0];
                C_PDIV: begin
                    r_lo <= w_lo;
                    if (!w_need) r_tmp <= w_src_t;
                end
                C_PSRC:  r_tmp <= w_push_t;
                C_FIN: begin
                    if (w_ax) r_srcy[r_m] <= w_fin;
                    else      r_srcx[r_m] <= w_fin;
                end
                C_ZOOM:  r_zoom[r_m] <= w_zeff;
                C_PLACE: begin
                    if (r_edge[1]) r_ply <= w_plsat;
                    else           r_plx <= w_plsat;
                end
                C_OUT: begin
                    r_vx <= r_srcx[r_m];
                    r_vy <= r_srcy[r_m];
                    r_ox <= r_plx;
                    r_oy <= r_ply;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.push_go   = r_pe && (w_zoom > ZOOM_ONE);
    assign o_stat.push_need = w_need;
    assign o_stat.edge_far  = r_edge[0];
    assign o_stat.div_done  = w_done;

    assign o_view_x   = r_vx;
    assign o_view_y   = r_vy;
    assign o_placed_x = r_ox;
    assign o_placed_y = r_oy;

endmodule

// File: rtl/core/zoom_viewport_edge_push_pan_core.sv
// ============================================================================
// zoom_viewport_edge_push_pan_core
// Per-monitor magnified viewport table with edge-push panning, zoom about
// the pointer and pointer placement on monitor entry.
// ============================================================================
//
//  channel | direction | handshake              | transfer when
//  --------+-----------+------------------------+--------------------------
//  in      | into core | i_in_valid / o_in_stall | valid high, stall low
//  out     | from core | o_out_valid/i_out_stall | valid high, stall low
//  cfg     | into core | i_cfg_valid/o_cfg_ready | valid and ready high
//
// One item at a time. Each divide on the shared divider holds the sequencer
// in a wait state until its quotient is ready. pointer_moved adds a divide
// for each axis that pans and goes straight to the output with panning off
// or the view at 1.0; place_on_entry divides only for a right or bottom edge.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled result only holds the next item in its final step.
// Reset is synchronous and loads every slot with its default view.
// Configuration writes are always taken.
module zoom_viewport_edge_push_pan_core #(
    parameter int MAX_MONITORS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [zvp_pkg::OPW-1:0]            i_operation,
    input  logic [zvp_pkg::MONW-1:0]           i_monitor,
    input  logic signed [zvp_pkg::PW-1:0]      i_pointer_x,
    input  logic signed [zvp_pkg::PW-1:0]      i_pointer_y,
    input  logic signed [zvp_pkg::CW-1:0]      i_rect_left,
    input  logic signed [zvp_pkg::CW-1:0]      i_rect_top,
    input  logic [zvp_pkg::SZW-1:0]            i_rect_width,
    input  logic [zvp_pkg::SZW-1:0]            i_rect_height,
    input  logic [zvp_pkg::ZW-1:0]             i_zoom_request,
    input  logic [zvp_pkg::EW-1:0]             i_entry_edge,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [zvp_pkg::VW-1:0]             o_view_x,
    output logic [zvp_pkg::VW-1:0]             o_view_y,
    output logic signed [zvp_pkg::PW-1:0]      o_placed_x,
    output logic signed [zvp_pkg::PW-1:0]      o_placed_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [zvp_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [zvp_pkg::CFG_DW-1:0]         i_cfg_data
);
    import zvp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    zvp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    zvp_dpath #(
        .MAX_MONITORS (MAX_MONITORS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_monitor      (i_monitor),
        .i_pointer_x    (i_pointer_x),
        .i_pointer_y    (i_pointer_y),
        .i_rect_left    (i_rect_left),
        .i_rect_top     (i_rect_top),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_zoom_request (i_zoom_request),
        .i_entry_edge   (i_entry_edge),
        .o_view_x       (o_view_x),
        .o_view_y       (o_view_y),
        .o_placed_x     (o_placed_x),
        .o_placed_y     (o_placed_y)
    );

endmodule
